// File: rtl/core/swa_pkg.sv
// Shared types and constants for the sliding window average unit.
`default_nettype none

package swa_pkg;

  // Width of the window length register
  localparam int unsigned WinLenW = 7;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // take the input word into the ring and registers
    logic update;     // fold the new sample into the running sum
    logic div_start;  // launch the divider on the updated sum
    logic out_load;   // move the quotient into the output register
  } swa_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic emit;       // window is full after this sample
    logic div_busy;   // divider still iterating
    logic out_free;   // output register can take a word this cycle
  } swa_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/swa_div.sv
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
`default_nettype none

module swa_div #(
  parameter int unsigned SumW = 22,
  parameter int unsigned KW   = 7
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic signed [SumW-1:0] dividend_i,
  input  wire logic        [KW-1:0]   divisor_i,
  output logic                        busy_o,
  output logic signed [SumW-1:0]      quot_o
);

  localparam int unsigned CntW = $clog2(SumW + 1);

  logic [SumW-1:0] mag_q, mag_d;
  logic [KW-1:0]   rem_q, rem_d;
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [KW:0]     trial;
  logic            qbit;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, mag_q[SumW-1]};
    qbit  = (trial >= {1'b0, divisor_i});
    mag_d  = mag_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      neg_d  = dividend_i[SumW-1];
      mag_d  = dividend_i[SumW-1] ? SumW'(-dividend_i) : SumW'(dividend_i);
      rem_d  = '0;
      cnt_d  = CntW'(SumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      mag_d = {mag_q[SumW-2:0], qbit};
      rem_d = qbit ? KW'(trial - {1'b0, divisor_i}) : trial[KW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand registers
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign busy_o = busy_q;
  assign quot_o = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

`default_nettype wire

// File: rtl/core/swa_dp.sv
// Datapath: sample ring, running sum, fill count, divider and output register.
`default_nettype none

module swa_dp #(
  parameter int unsigned MaxWindow  = 64,
  parameter int unsigned SampleBits = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire swa_pkg::swa_cmd_t            cmd_i,
  output swa_pkg::swa_sts_t                 sts_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [swa_pkg::WinLenW-1:0]  cfg_wdata_i,
  input  wire logic signed [SampleBits-1:0] sample_i,
  input  wire logic                         new_sequence_i,
  input  wire logic                         out_stall_i,
  output logic                              out_valid_o,
  output logic signed [SampleBits-1:0]      average_o
);
  import swa_pkg::*;

  localparam int unsigned PtrW = $clog2(MaxWindow);
  localparam int unsigned KW   = $clog2(MaxWindow + 1);
  localparam int unsigned SumW = SampleBits + $clog2(MaxWindow);
  localparam int unsigned CmpW = (KW > WinLenW) ? KW : WinLenW;
  localparam int unsigned OffW = KW + 1;

  logic signed [SampleBits-1:0] ring_mem [MaxWindow];
  logic signed [SampleBits-1:0] rd_q;
  logic signed [SampleBits-1:0] sample_q;
  logic signed [SumW-1:0]       sum_q, sum_d;
  logic [KW-1:0]                fill_q, fill_d, fill_base;
  logic [KW-1:0]                k_q, k_d;
  logic [PtrW-1:0]              wp_q, wp_d, old_addr;
  logic                         full_q, full_d;
  logic                         emit_q, emit_d;
  logic                         out_valid_q;
  logic signed [SampleBits-1:0] average_q;
  logic [CmpW-1:0]              wl_ext;
  logic [OffW-1:0]              wp_ext, k_ext, off_diff;
  logic signed [SumW-1:0]       quot;
  logic                         div_busy;

  // Effective window length: zero reads as one, clamp to ring depth
  always_comb begin
    wl_ext = CmpW'(cfg_wdata_i);
    if (wl_ext == '0) begin
      k_d = KW'(1);
    end else if (wl_ext > CmpW'(MaxWindow)) begin
      k_d = KW'(MaxWindow);
    end else begin
      k_d = KW'(wl_ext);
    end
  end

  // Slot of the sample that leaves the window
  always_comb begin
    wp_ext   = OffW'(wp_q);
    k_ext    = OffW'(k_q);
    off_diff = wp_ext - k_ext;
    if (wp_ext < k_ext) begin
      off_diff = off_diff + OffW'(MaxWindow);
    end
    old_addr = PtrW'(off_diff);
  end

  // Fill count and pointer bookkeeping for an accepted word
  always_comb begin
    fill_base = new_sequence_i ? '0 : ((fill_q > k_q) ? k_q : fill_q);
    full_d    = (fill_base == k_q);
    fill_d    = full_d ? fill_base : KW'(fill_base + 1'b1);
    emit_d    = (fill_d == k_q);
    wp_d      = (wp_q == PtrW'(MaxWindow - 1)) ? '0 : PtrW'(wp_q + 1'b1);
  end

  // Running sum: add new sample, drop the outgoing one when full
  always_comb begin
    sum_d = sum_q + SumW'(sample_q);
    if (full_q) begin
      sum_d = sum_d - SumW'(rd_q);
    end
  end

  // Control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= KW'(1);
      fill_q      <= '0;
      sum_q       <= '0;
      wp_q        <= '0;
      full_q      <= 1'b0;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        k_q    <= k_d;
        fill_q <= '0;
        sum_q  <= '0;
      end else if (cmd_i.accept) begin
        fill_q <= fill_d;
        wp_q   <= wp_d;
        full_q <= full_d;
        emit_q <= emit_d;
        if (new_sequence_i) begin
          sum_q <= '0;
        end
      end else if (cmd_i.update) begin
        sum_q <= sum_d;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Ring store: read the outgoing slot before this word overwrites it
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_q               <= ring_mem[old_addr];
      ring_mem[wp_q]     <= sample_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_i;
    end
    if (cmd_i.out_load) begin
      average_q <= SampleBits'(quot);
    end
  end

  swa_div #(
    .SumW (SumW),
    .KW   (KW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_d),
    .divisor_i  (k_q),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign sts_o.emit     = emit_q;
  assign sts_o.div_busy = div_busy;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign average_o      = average_q;

endmodule

`default_nettype wire

// File: rtl/core/swa_ctrl.sv
// Controller: sequences accept, sum update, division and output load.
`default_nettype none

module swa_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire swa_pkg::swa_sts_t sts_i,
  output swa_pkg::swa_cmd_t      cmd_o
);
  import swa_pkg::*;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StUpdate = 2'd1;
  localparam logic [1:0] StDivide = 2'd2;

  logic [1:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StUpdate;
        end
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        if (sts_i.emit) begin
          cmd_o.div_start = 1'b1;
          state_d         = StDivide;
        end else begin
          state_d = StIdle;
        end
      end
      StDivide: begin
        if (!sts_i.div_busy && sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

`default_nettype wire

// File: rtl/core/sliding_window_average_unit.sv
// Top level of the sliding window (boxcar) average unit.
// Usage:
//   Input channel: sample_i and new_sequence_i, qualified by in_valid_i; a word
//   is taken at a clock edge with in_valid_i high and in_stall_o low.
//   new_sequence_i marks the first sample of a data set and restarts the window.
//   Output channel: average_o with out_valid_o; the word is taken when
//   out_stall_i is low. The value is the window sum divided by the window
//   length, truncated toward zero, given once the window holds that many
//   samples of the current set; earlier samples give no word.
//   Configuration: cfg_we_i writes cfg_wdata_i as the window length (0 acts
//   as 1, values above MAX_WINDOW act as MAX_WINDOW) and restarts the window.
//   Write it only while the unit is idle.
// Timing: a sample with no result passes through the accept and update steps.
//   A sample with a result then waits for the bit-per-cycle restoring divider,
//   and the result is loaded into the output register once the divider has
//   finished and that register is free.
// The output register holds a finished word while the receiver stalls; the
//   next sample is taken meanwhile, and the unit waits at the end of its
//   division only if the earlier word is still not taken.
// Reset: window length 1, empty window, output channel empty; no ring clearing.
`default_nettype none

module sliding_window_average_unit #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [swa_pkg::WinLenW-1:0]   cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire logic                          new_sequence_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]      average_o
);
  import swa_pkg::*;

  swa_cmd_t cmd;
  swa_sts_t sts;

  swa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  swa_dp #(
    .MaxWindow  (MAX_WINDOW),
    .SampleBits (SAMPLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .sample_i       (sample_i),
    .new_sequence_i (new_sequence_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .average_o      (average_o)
  );

endmodule

`default_nettype wire
